// ----- rtl/dttc_pkg.sv -----
// Shared types, constants and helpers for the decimal text to cents parser.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps

package dttc_pkg;

  // Sizing
  localparam int MAX_WHOLE_DIGITS = 16;
  localparam int AMT_W            = 60;
  localparam int CHAR_W           = 8;
  localparam int CNT_W            = $clog2(MAX_WHOLE_DIGITS + 1);
  localparam int DIGIT_W          = 4;
  localparam int CENTS_W          = 7;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

  // Third fractional digit at or above this value rounds up
  localparam logic [DIGIT_W-1:0] ROUND_MIN = 4'd5;

  // Fractional digit position codes
  localparam logic [1:0] FRAC_NONE  = 2'd0;
  localparam logic [1:0] FRAC_TENTH = 2'd1;
  localparam logic [1:0] FRAC_HUND  = 2'd2;
  localparam logic [1:0] FRAC_DONE  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_SECOND_DOT = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // One captured request from the input register
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_terminator;
  } req_t;

  // Totals captured at a terminator; cents is 0..100
  typedef struct packed {
    logic [AMT_W-1:0]   whole;
    logic [CENTS_W-1:0] cents;
    status_t            status;
  } snap_t;

  // x*10 + d by shift and add, wrapped to the amount width
  function automatic logic [AMT_W-1:0] shift_in_digit(input logic [AMT_W-1:0] x,
                                                      input logic [DIGIT_W-1:0] d);
    shift_in_digit = (x << 3) + (x << 1) + AMT_W'(d);
  endfunction

endpackage

// ----- rtl/dttc_in_stage.sv -----
// Input register of the decimal text to cents parser.
// Depends on dttc_pkg for the request type.
`timescale 1ns / 1ps

module dttc_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dttc_pkg::CHAR_W-1:0] char_code,
  input  logic                       is_terminator,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       take,
  output dttc_pkg::req_t             req,
  output logic                       req_valid
);
  import dttc_pkg::*;

  // Stall only while a held request is not consumed downstream
  assign in_stall = req_valid && !take;

  // Hold valid
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req.char_code     <= char_code;
      req.is_terminator <= is_terminator;
    end
  end

endmodule

// ----- rtl/dttc_parse.sv -----
// Parser state: folds one character per cycle into the running totals and
// captures a snapshot on a terminator once its slot is free. Depends on dttc_pkg.
`timescale 1ns / 1ps

module dttc_parse (
  input  logic            clk,
  input  logic            rst,
  input  dttc_pkg::req_t  req,
  input  logic            req_valid,
  output logic            take,
  input  logic            sc_take,
  output dttc_pkg::snap_t snap,
  output logic            snap_valid
);
  import dttc_pkg::*;

  logic [AMT_W-1:0]   whole_accum, whole_accum_next;
  logic [CNT_W-1:0]   whole_digit_count, whole_digit_count_next;
  logic               dot_seen, dot_seen_next;
  logic [1:0]         frac_digit_count, frac_digit_count_next;
  logic [CENTS_W-1:0] frac_two_digits, frac_two_digits_next;
  logic               round_up_flag, round_up_flag_next;
  status_t            error_code, error_code_next;

  logic               snap_free;
  logic               is_digit;
  logic [DIGIT_W-1:0] digit;
  logic [CHAR_W-1:0]  digit_full;

  // Snapshot slot opens when empty or being drained
  assign snap_free = !snap_valid || sc_take;
  assign take      = req_valid && (!req.is_terminator || snap_free);

  assign is_digit   = (req.char_code >= CH_ZERO) && (req.char_code <= CH_NINE);
  assign digit_full = req.char_code - CH_ZERO;
  assign digit      = digit_full[DIGIT_W-1:0];

  // Next state for one character
  always_comb begin
    whole_accum_next       = whole_accum;
    whole_digit_count_next = whole_digit_count;
    dot_seen_next          = dot_seen;
    frac_digit_count_next  = frac_digit_count;
    frac_two_digits_next   = frac_two_digits;
    round_up_flag_next     = round_up_flag;
    error_code_next        = error_code;
    if (error_code == ST_OK) begin
      if (is_digit) begin
        if (!dot_seen) begin
          // Zero count means the accumulator is still zero: drop leading zeros
          if (!(whole_digit_count == '0 && digit == '0)) begin
            if (whole_digit_count >= CNT_W'(MAX_WHOLE_DIGITS)) begin
              error_code_next = ST_OVERFLOW;
            end else begin
              whole_accum_next       = shift_in_digit(whole_accum, digit);
              whole_digit_count_next = whole_digit_count + 1'b1;
            end
          end
        end else begin
          case (frac_digit_count)
            FRAC_NONE: begin
              frac_two_digits_next  = (CENTS_W'(digit) << 3) + (CENTS_W'(digit) << 1);
              frac_digit_count_next = FRAC_TENTH;
            end
            FRAC_TENTH: begin
              frac_two_digits_next  = frac_two_digits + CENTS_W'(digit);
              frac_digit_count_next = FRAC_HUND;
            end
            FRAC_HUND: begin
              round_up_flag_next    = (digit >= ROUND_MIN);
              frac_digit_count_next = FRAC_DONE;
            end
            default: begin
              frac_digit_count_next = frac_digit_count;
            end
          endcase
        end
      end else if (req.char_code == CH_COMMA) begin
        error_code_next = ST_OK;
      end else if (req.char_code == CH_DOT) begin
        if (dot_seen) begin
          error_code_next = ST_SECOND_DOT;
        end else begin
          dot_seen_next = 1'b1;
        end
      end else begin
        error_code_next = ST_BAD_CHAR;
      end
    end
  end

  // Advance state on characters, clear on terminators
  always_ff @(posedge clk) begin
    if (rst) begin
      whole_accum       <= '0;
      whole_digit_count <= '0;
      dot_seen          <= 1'b0;
      frac_digit_count  <= FRAC_NONE;
      frac_two_digits   <= '0;
      round_up_flag     <= 1'b0;
      error_code        <= ST_OK;
    end else if (take) begin
      if (req.is_terminator) begin
        whole_accum       <= '0;
        whole_digit_count <= '0;
        dot_seen          <= 1'b0;
        frac_digit_count  <= FRAC_NONE;
        frac_two_digits   <= '0;
        round_up_flag     <= 1'b0;
        error_code        <= ST_OK;
      end else begin
        whole_accum       <= whole_accum_next;
        whole_digit_count <= whole_digit_count_next;
        dot_seen          <= dot_seen_next;
        frac_digit_count  <= frac_digit_count_next;
        frac_two_digits   <= frac_two_digits_next;
        round_up_flag     <= round_up_flag_next;
        error_code        <= error_code_next;
      end
    end
  end

  // Hold snapshot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= req_valid && req.is_terminator;
    end
  end

  // Capture totals; cents may reach 100, which the scaler folds into whole
  always_ff @(posedge clk) begin
    if (take && req.is_terminator) begin
      snap.whole  <= whole_accum;
      snap.cents  <= frac_two_digits + CENTS_W'(round_up_flag);
      snap.status <= error_code;
    end
  end

endmodule

// ----- rtl/dttc_scale.sv -----
// Output stage: scales the whole part by 100, adds cents, and holds the result.
// Depends on dttc_pkg.
`timescale 1ns / 1ps

module dttc_scale (
  input  logic                       clk,
  input  logic                       rst,
  input  dttc_pkg::snap_t            snap,
  input  logic                       snap_valid,
  output logic                       sc_take,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [dttc_pkg::AMT_W-1:0] amount_cents,
  output dttc_pkg::status_t          status
);
  import dttc_pkg::*;

  logic             out_free;
  logic [AMT_W-1:0] amount_next;

  assign out_free = !out_valid || !out_stall;
  assign sc_take  = snap_valid && out_free;

  // whole*100 + cents; cents of 100 carries into whole for free
  assign amount_next = (snap.whole << 6) + (snap.whole << 5) + (snap.whole << 2)
                     + AMT_W'(snap.cents);

  // Hold valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= snap_valid;
    end
  end

  // Load result; zero the amount on error
  always_ff @(posedge clk) begin
    if (sc_take) begin
      status       <= snap.status;
      amount_cents <= (snap.status == ST_OK) ? amount_next : '0;
    end
  end

endmodule

// ----- rtl/decimal_text_to_cents.sv -----
// Decimal text to cents: takes one ASCII character per request and, on a
// terminator request, returns the amount in hundredths with a status code.
// Depends on dttc_pkg, dttc_in_stage, dttc_parse and dttc_scale.
`timescale 1ns / 1ps

// One request is accepted every cycle while in_stall is low. A character is
// captured in the input register and then folded into the running totals, one
// shift-add of the whole part per character; a terminator's result passes from
// the input register through the snapshot register to the output register
// after the scale-by-100 add. Commas are skipped, up to 16 significant whole
// digits are taken, the third fractional digit rounds half up, and the state
// clears after every terminator. A result waiting on out_stall does not
// block input until the snapshot slot behind it is also full and a
// terminator arrives.
module decimal_text_to_cents (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dttc_pkg::CHAR_W-1:0] char_code,
  input  logic                       is_terminator,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic [dttc_pkg::AMT_W-1:0] amount_cents,
  output logic [1:0]                 status,
  output logic                       out_valid,
  input  logic                       out_stall
);
  import dttc_pkg::*;

  req_t    req;
  logic    req_valid;
  logic    take;
  snap_t   snap;
  logic    snap_valid;
  logic    sc_take;
  status_t status_q;

  dttc_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .char_code     (char_code),
    .is_terminator (is_terminator),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .take          (take),
    .req           (req),
    .req_valid     (req_valid)
  );

  dttc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .req_valid  (req_valid),
    .take       (take),
    .sc_take    (sc_take),
    .snap       (snap),
    .snap_valid (snap_valid)
  );

  dttc_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .snap         (snap),
    .snap_valid   (snap_valid),
    .sc_take      (sc_take),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .amount_cents (amount_cents),
    .status       (status_q)
  );

  assign status = status_q;

  // An empty input register never stalls
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !req_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  // A nonzero amount only comes with an ok status
  a_amount_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (amount_cents != '0) |-> status_q == ST_OK)
    else $error("nonzero amount with error status");

  // Amount never exceeds 10^18 cents
  a_amount_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> amount_cents <= 60'd1000000000000000000)
    else $error("amount beyond range");

  // A character request never occupies the snapshot slot
  a_char_no_snap: assert property (@(posedge clk) disable iff (rst)
    take && !req.is_terminator && !snap_valid |=> !snap_valid)
    else $error("snapshot filled by a character request");

endmodule

// ----- test/cents_checker.sv -----
// Scoreboard for decimal_text_to_cents: watches both channels, predicts each amount.
// Depends on dttc_pkg for widths, character codes and status_t.
`timescale 1ns / 1ps

module cents_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dttc_pkg::CHAR_W-1:0] char_code,
  input  logic                        is_terminator,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [dttc_pkg::AMT_W-1:0]  amount_cents,
  input  logic [1:0]                  status,
  input  logic                        out_valid,
  input  logic                        out_stall,
  output int                          fail_count,
  output int                          owed_count,
  output int                          texts_done
);
  import dttc_pkg::*;

  typedef struct packed {
    logic [AMT_W-1:0] amount;
    status_t          code;
  } amount_t;

  // Amounts predicted for accepted terminators, oldest first
  amount_t owed_amounts[$];

  // Parser shadow state
  logic [AMT_W-1:0]   acc_whole;
  logic [CNT_W-1:0]   sig_digits;
  logic               saw_dot;
  logic [1:0]         frac_pos;
  logic [CENTS_W-1:0] frac_cents;
  logic               round_bump;
  status_t            first_err;

  int errs;
  int texts;

  task automatic clear_parse();
    acc_whole  = '0;
    sig_digits = '0;
    saw_dot    = 1'b0;
    frac_pos   = FRAC_NONE;
    frac_cents = '0;
    round_bump = 1'b0;
    first_err  = ST_OK;
  endtask

  // Fold one character into the shadow state; the first error sticks
  task automatic absorb_char(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_W'(c - CH_ZERO);
    if (first_err != ST_OK) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!saw_dot) begin
        // leading zeros do not count as significant digits
        if (acc_whole == '0 && d == '0) begin
        end else if (sig_digits >= MAX_WHOLE_DIGITS) begin
          first_err = ST_OVERFLOW;
        end else begin
          acc_whole  = acc_whole * 10 + d;
          sig_digits = sig_digits + 1'b1;
        end
      end else begin
        case (frac_pos)
          FRAC_NONE: begin
            frac_cents = d * 10;
            frac_pos   = FRAC_TENTH;
          end
          FRAC_TENTH: begin
            frac_cents = frac_cents + d;
            frac_pos   = FRAC_HUND;
          end
          FRAC_HUND: begin
            round_bump = (d >= ROUND_MIN);
            frac_pos   = FRAC_DONE;
          end
          default: begin
          end
        endcase
      end
    end else if (c == CH_COMMA) begin
    end else if (c == CH_DOT) begin
      if (saw_dot) first_err = ST_SECOND_DOT;
      else saw_dot = 1'b1;
    end else begin
      first_err = ST_BAD_CHAR;
    end
  endtask

  // Amount owed for the text parsed so far, with the rounding carry applied
  function automatic amount_t settle_amount();
    logic [AMT_W-1:0] whole;
    logic [7:0]       cents;
    amount_t          owed;
    if (first_err != ST_OK) begin
      owed.amount = '0;
      owed.code   = first_err;
    end else begin
      whole = acc_whole;
      cents = {1'b0, frac_cents} + round_bump;
      if (cents >= 100) begin
        whole = whole + 1'b1;
        cents = '0;
      end
      owed.amount = whole * 100 + cents;
      owed.code   = ST_OK;
    end
    return owed;
  endfunction

  // Compare results first, then fold in the request taken at the same edge
  always @(posedge clk) begin
    amount_t want;
    if (rst) begin
      clear_parse();
      owed_amounts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_amounts.size() == 0) begin
          errs++;
          $display("%0t: unexpected result amount %0d status %0d", $time, amount_cents,
                   status);
        end else begin
          want = owed_amounts.pop_front();
          if (amount_cents !== want.amount) begin
            errs++;
            $display("%0t: amount_cents expected %0d actual %0d", $time, want.amount,
                     amount_cents);
          end
          if (status !== want.code) begin
            errs++;
            $display("%0t: status expected %0d actual %0d", $time, want.code, status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (is_terminator) begin
          owed_amounts.push_back(settle_amount());
          clear_parse();
          texts++;
        end else begin
          absorb_char(char_code);
        end
      end
    end
    fail_count <= errs;
    owed_count <= owed_amounts.size();
    texts_done <= texts;
  end

endmodule

// ----- test/tb.sv -----
// Top of the decimal_text_to_cents bench: clock, reset, text stimulus and verdict.
// Depends on dttc_pkg, the decimal_text_to_cents RTL and cents_checker.
`timescale 1ns / 1ps

module tb;
  import dttc_pkg::*;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic [CHAR_W-1:0] char_code     = '0;
  logic              is_terminator = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [AMT_W-1:0]  amount_cents;
  logic [1:0]        status;
  logic              out_valid;
  logic              out_stall     = 1'b0;

  int fail_count;
  int owed_count;
  int texts_done;
  int chars_sent;
  int hold_left;
  bit in_burst;
  bit out_burst;

  // Edge cases: padding, rounding carry, comma skipping, digit limit, errors
  string directed_texts[$] = '{
    "", "0", "000", ",,", ".", ".5", "5.", "1,234.567", "0.995", "0.994", "0.005",
    "99.999", "12.3456789", "9999999999999999.995", "9,999,999,999,999,999",
    "0001234567890123456", "12345678901234567", "1.2.3", "a1.2", "-5", " 7",
    "\200", "\377"
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  decimal_text_to_cents u_dut (
    .clk           (clk),
    .rst           (rst),
    .char_code     (char_code),
    .is_terminator (is_terminator),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .amount_cents  (amount_cents),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  cents_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .char_code     (char_code),
    .is_terminator (is_terminator),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .amount_cents  (amount_cents),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fail_count    (fail_count),
    .owed_count    (owed_count),
    .texts_done    (texts_done)
  );

  // Draw a wait for each result on its acceptance; stall the next one that long
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      n = out_burst ? 0 : $urandom_range(0, 6);
      hold_left <= n;
      out_stall <= (n != 0);
    end else if (out_valid && hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) out_stall <= 1'b0;
    end
  end

  // Present one request after a drawn idle gap and wait for it to be taken
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_code     <= c;
    is_terminator <= last;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input logic [CHAR_W-1:0] txt[$]);
    foreach (txt[i]) send_char(txt[i], 1'b0);
    send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CHAR_W'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // Mostly well-formed amounts with random content; the rest is junk or broken
  task automatic send_random_text();
    logic [CHAR_W-1:0] txt[$];
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) txt.push_back(CH_ZERO);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        txt.push_back(rand_digit());
        if (i < n - 1 && $urandom_range(0, 3) == 0) txt.push_back(CH_COMMA);
      end
      if ($urandom_range(0, 3) != 0) begin
        txt.push_back(CH_DOT);
        repeat ($urandom_range(0, 5)) txt.push_back(rand_digit());
      end
      // break the amount with a stray byte or an extra dot
      if (kind == 6) begin
        txt.insert($urandom_range(0, txt.size()),
                   $urandom_range(0, 1) ? CH_DOT : CHAR_W'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 3))
          0:       txt.push_back(CH_DOT);
          1:       txt.push_back(CH_COMMA);
          2:       txt.push_back(rand_digit());
          default: txt.push_back(CHAR_W'($urandom_range(0, 255)));
        endcase
      end
    end
    send_text(txt);
  endtask

  initial begin
    logic [CHAR_W-1:0] txt[$];
    int directed_chars;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed texts
    foreach (directed_texts[k]) begin
      txt.delete();
      for (int i = 0; i < directed_texts[k].len(); i++) txt.push_back(directed_texts[k][i]);
      send_text(txt);
    end
    directed_chars = chars_sent;

    // Random texts, with stretches of back-to-back traffic on either side
    while (chars_sent - directed_chars < 1000) begin
      if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
      if ($urandom_range(0, 15) == 0) out_burst <= !out_burst;
      send_random_text();
    end
    in_valid <= 1'b0;

    // Drain outstanding amounts, then let the pipeline settle
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d requests over %0d texts, directed edge cases then random text",
             chars_sent, texts_done);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d amounts outstanding", owed_count);
    $display("tb: errors");
    $finish;
  end

endmodule
